FILE: design/pfc_pkg.sv
// pfc_pkg: shared types and constants for the playfair digraph cipher
// control word, sequencer status bundle, step numbers and command codes
// no dependencies
`default_nettype none

package pfc_pkg;

    localparam int LW = 5;

    typedef logic [LW-1:0] ltr_t;
    typedef logic [4:0]    step_t;

    // command codes on the opcode field
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_KEY    = 3'd1;
    localparam logic [2:0] OP_FINISH = 3'd2;
    localparam logic [2:0] OP_TEXT   = 3'd3;
    localparam logic [2:0] OP_END    = 3'd4;

    localparam ltr_t LTR_I    = 5'd8;
    localparam ltr_t LTR_J    = 5'd9;
    localparam ltr_t LTR_X    = 5'd23;
    localparam ltr_t LTR_MAX  = 5'd25;
    localparam ltr_t SQ_SIZE  = 5'd25;

    // finish iterator: keyword CIPHER at 0..5, the J-less alphabet at 6..30
    localparam ltr_t FIN_ALPHA = 5'd6;
    localparam ltr_t FIN_LAST  = 5'd30;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_WAIT,
        ACT_CLEAR,
        ACT_PLACE_KEY,
        ACT_FIN_INIT,
        ACT_FIN_PLACE,
        ACT_SET_READY,
        ACT_HOLD,
        ACT_EMIT_ERR,
        ACT_LOAD_X,
        ACT_RD_SLOT_A,
        ACT_RD_SLOT_B,
        ACT_CALC,
        ACT_RD_SQ_X,
        ACT_RD_SQ_Y,
        ACT_EMIT_PAIR
    } act_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_READY,
        COND_NOT_READY,
        COND_HELD,
        COND_NOT_HELD,
        COND_ITER_MORE,
        COND_DISPATCH
    } cond_t;

    typedef struct packed {
        act_t  act;
        logic  emit;
        cond_t cond;
        step_t target;
    } ctl_t;

    typedef struct packed {
        logic       fire;
        logic [2:0] opcode;
        logic       letter_ok;
        logic       key_ready;
        logic       held_valid;
        logic       iter_more;
        logic       out_busy;
    } stat_t;

    // microprogram step numbers
    localparam step_t ST_IDLE     = 5'd0;
    localparam step_t ST_CLEAR    = 5'd1;
    localparam step_t ST_KEY      = 5'd2;
    localparam step_t ST_FIN_CHK  = 5'd3;
    localparam step_t ST_FIN_LOOP = 5'd4;
    localparam step_t ST_FIN_DONE = 5'd5;
    localparam step_t ST_TXT_CHK  = 5'd6;
    localparam step_t ST_TXT_HELD = 5'd7;
    localparam step_t ST_TXT_HOLD = 5'd8;
    localparam step_t ST_ERR      = 5'd9;
    localparam step_t ST_END_CHK  = 5'd10;
    localparam step_t ST_END_X    = 5'd11;
    localparam step_t ST_P_RDA    = 5'd12;
    localparam step_t ST_P_RDB    = 5'd13;
    localparam step_t ST_P_CALC   = 5'd14;
    localparam step_t ST_P_RDX    = 5'd15;
    localparam step_t ST_P_RDY    = 5'd16;
    localparam step_t ST_P_EMIT   = 5'd17;

endpackage

`default_nettype wire

FILE: design/playfair_digraph_cipher.sv
// playfair_digraph_cipher: top level, datapath with key square and letter slot memories
// depends on pfc_pkg and pfc_seq
//
//   channel  signals                                        dir
//   input    in_valid, in_ready, opcode, letter             in
//   output   out_valid, out_ready, first_letter,
//            second_letter, status                          out
//   config   cfg_valid, cfg_ready, cfg_data (direction)     in
//
// finish walks its list one place per cycle: the keyword CIPHER when no key letter was placed,
// then the J-less alphabet; once any key letter is placed, the walk starts at the alphabet.
// a pair takes four single-port reads in turn: two letter slots, then two square cells.
// rst_n clears key state, held letter, direction and the output valid flag; memories keep contents.
// a result waits in the output register while the next transaction is taken; the
// sequencer holds only when a second result finds it still full.
`default_nettype none

module playfair_digraph_cipher (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        opcode,
    input  wire pfc_pkg::ltr_t     letter,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pfc_pkg::ltr_t          first_letter,
    output pfc_pkg::ltr_t          second_letter,
    output logic                   status,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data
);
    import pfc_pkg::*;

    ctl_t  ctl;
    stat_t st;
    logic  fire;

    ltr_t  sq_mem [SQ_SIZE];
    ltr_t  slot_mem [LTR_MAX + 5'd1];

    logic [24:0] seen_reg, seen_next;
    ltr_t  fill_reg, fill_next;
    logic  ready_reg, ready_next;
    ltr_t  held_reg, held_next;
    logic  held_valid_reg, held_valid_next;
    ltr_t  cur_reg, cur_next;
    ltr_t  iter_reg, iter_next;
    logic  dir_reg, dir_next;
    ltr_t  pa_reg, pa_next;
    ltr_t  x_reg, x_next;
    ltr_t  y_reg, y_next;
    ltr_t  tmp_reg, tmp_next;
    logic  ov_reg, ov_next;
    ltr_t  o1_reg, o1_next;
    ltr_t  o2_reg, o2_next;
    logic  ost_reg, ost_next;
    ltr_t  sq_rd_reg;
    ltr_t  slot_rd_reg;

    ltr_t  place_code;
    ltr_t  place_bit;
    logic  place_en;
    ltr_t  slot_addr;
    ltr_t  sq_addr;
    logic [2:0] r1, c1, r2, c2, sh;
    logic [2:0] nr1, nc1, nr2, nc2;

    function automatic ltr_t fin_letter(ltr_t i);
        ltr_t v;
        case (i)
            5'd0:  v = 5'd2;   // C
            5'd1:  v = 5'd8;   // I
            5'd2:  v = 5'd15;  // P
            5'd3:  v = 5'd7;   // H
            5'd4:  v = 5'd4;   // E
            5'd5:  v = 5'd17;  // R
            default:
            begin
                // alphabet entries, skipping J
                if (i < 5'd15)
                    v = i - FIN_ALPHA;
                else
                    v = i - 5'd5;
            end
        endcase
        return v;
    endfunction

    function automatic logic [2:0] pos_row(ltr_t p);
        logic [2:0] r;
        if (p >= 5'd20)
            r = 3'd4;
        else if (p >= 5'd15)
            r = 3'd3;
        else if (p >= 5'd10)
            r = 3'd2;
        else if (p >= 5'd5)
            r = 3'd1;
        else
            r = 3'd0;
        return r;
    endfunction

    function automatic logic [2:0] pos_col(ltr_t p);
        ltr_t rx5;
        logic [2:0] r;
        r   = pos_row(p);
        rx5 = {r[2:0], 2'b00} + {2'b00, r};
        return 3'(p - rx5);
    endfunction

    function automatic logic [2:0] add_mod5(logic [2:0] v, logic [2:0] s);
        logic [3:0] t;
        t = {1'b0, v} + {1'b0, s};
        if (t >= 4'd5)
            t = t - 4'd5;
        return t[2:0];
    endfunction

    function automatic ltr_t to_pos(logic [2:0] r, logic [2:0] c);
        return {r[2:0], 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    pfc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctl   (ctl)
    );

    assign in_ready  = (ctl.act == ACT_WAIT);
    assign fire      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid     = ov_reg;
    assign first_letter  = o1_reg;
    assign second_letter = o2_reg;
    assign status        = ost_reg;

    always_comb
    begin
        st.fire       = fire;
        st.opcode     = opcode;
        st.letter_ok  = (letter <= LTR_MAX);
        st.key_ready  = ready_reg;
        st.held_valid = held_valid_reg;
        st.iter_more  = (iter_reg != FIN_LAST);
        st.out_busy   = ov_reg && !out_ready;
    end

    // letter placement, shared by key letters and the finish walk
    always_comb
    begin
        place_code = (ctl.act == ACT_FIN_PLACE) ? fin_letter(iter_reg) : cur_reg;
        place_bit  = (place_code < LTR_J) ? place_code : place_code - 5'd1;
        place_en   = ((ctl.act == ACT_PLACE_KEY && !ready_reg) || ctl.act == ACT_FIN_PLACE)
                     && !seen_reg[place_bit] && (fill_reg < SQ_SIZE);
    end

    // pair geometry from the two square positions
    always_comb
    begin
        sh  = dir_reg ? 3'd4 : 3'd1;
        r1  = pos_row(pa_reg);
        c1  = pos_col(pa_reg);
        r2  = pos_row(slot_rd_reg);
        c2  = pos_col(slot_rd_reg);
        nr1 = add_mod5(r1, sh);
        nc1 = add_mod5(c1, sh);
        nr2 = add_mod5(r2, sh);
        nc2 = add_mod5(c2, sh);
    end

    always_comb
    begin
        slot_addr = (ctl.act == ACT_RD_SLOT_B) ? cur_reg : held_reg;
        sq_addr   = (ctl.act == ACT_RD_SQ_Y) ? y_reg : x_reg;
    end

    always_comb
    begin
        seen_next       = seen_reg;
        fill_next       = fill_reg;
        ready_next      = ready_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        cur_next        = cur_reg;
        iter_next       = iter_reg;
        dir_next        = dir_reg;
        pa_next         = pa_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        tmp_next        = tmp_reg;
        ov_next         = ov_reg;
        o1_next         = o1_reg;
        o2_next         = o2_reg;
        ost_next        = ost_reg;

        if (cfg_valid)
            dir_next = cfg_data;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        if (fire)
            cur_next = (letter == LTR_J) ? LTR_I : letter;

        if (place_en)
        begin
            seen_next[place_bit] = 1'b1;
            fill_next            = fill_reg + 5'd1;
        end

        case (ctl.act)
            ACT_CLEAR:
            begin
                seen_next       = '0;
                fill_next       = '0;
                ready_next      = 1'b0;
                held_valid_next = 1'b0;
                held_next       = '0;
            end
            ACT_FIN_INIT:  iter_next = (fill_reg == 5'd0) ? 5'd0 : FIN_ALPHA;
            ACT_FIN_PLACE: iter_next = iter_reg + 5'd1;
            ACT_SET_READY: ready_next = 1'b1;
            ACT_HOLD:
            begin
                held_next       = cur_reg;
                held_valid_next = 1'b1;
            end
            ACT_EMIT_ERR:
            begin
                ov_next  = 1'b1;
                o1_next  = '0;
                o2_next  = '0;
                ost_next = 1'b1;
            end
            ACT_LOAD_X:    cur_next = LTR_X;
            ACT_RD_SLOT_B: pa_next = slot_rd_reg;
            ACT_CALC:
            begin
                if (r1 == r2 && c1 == c2)
                begin
                    x_next = to_pos(nr1, nc1);
                    y_next = to_pos(nr1, nc1);
                end
                else if (r1 == r2)
                begin
                    x_next = to_pos(r1, nc1);
                    y_next = to_pos(r2, nc2);
                end
                else if (c1 == c2)
                begin
                    x_next = to_pos(nr1, c1);
                    y_next = to_pos(nr2, c2);
                end
                else
                begin
                    // rectangle corners
                    x_next = to_pos(r1, c2);
                    y_next = to_pos(r2, c1);
                end
            end
            ACT_RD_SQ_Y:   tmp_next = sq_rd_reg;
            ACT_EMIT_PAIR:
            begin
                ov_next         = 1'b1;
                o1_next         = tmp_reg;
                o2_next         = sq_rd_reg;
                ost_next        = 1'b0;
                held_valid_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            fill_reg       <= '0;
            ready_reg      <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            iter_reg       <= '0;
            dir_reg        <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            seen_reg       <= seen_next;
            fill_reg       <= fill_next;
            ready_reg      <= ready_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            iter_reg       <= iter_next;
            dir_reg        <= dir_next;
            ov_reg         <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        pa_reg  <= pa_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        tmp_reg <= tmp_next;
        o1_reg  <= o1_next;
        o2_reg  <= o2_next;
        ost_reg <= ost_next;
    end

    // key square and letter slot memories, one write and one registered read each
    // the square read holds its data while the emit step waits on the output
    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            sq_mem[fill_reg]     <= place_code;
            slot_mem[place_code] <= fill_reg;
        end
        if (ctl.act == ACT_RD_SQ_X || ctl.act == ACT_RD_SQ_Y)
            sq_rd_reg <= sq_mem[sq_addr];
        slot_rd_reg <= slot_mem[slot_addr];
    end

endmodule

`default_nettype wire

FILE: design/pfc_seq.sv
// pfc_seq: microprogram sequencer with step counter, control rom and jumps
// depends on pfc_pkg
`default_nettype none

module pfc_seq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pfc_pkg::stat_t st,
    output pfc_pkg::ctl_t      ctl
);
    import pfc_pkg::*;

    step_t upc_reg;
    step_t upc_next;
    ctl_t  word;
    logic  stall;
    logic  jump;
    step_t entry;

    function automatic ctl_t mk(act_t a, logic e, cond_t c, step_t t);
        ctl_t w;
        w.act    = a;
        w.emit   = e;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic ctl_t rom(step_t s);
        ctl_t w;
        case (s)
            ST_IDLE:     w = mk(ACT_WAIT,      1'b0, COND_DISPATCH,  ST_IDLE);
            ST_CLEAR:    w = mk(ACT_CLEAR,     1'b0, COND_ALWAYS,    ST_IDLE);
            ST_KEY:      w = mk(ACT_PLACE_KEY, 1'b0, COND_ALWAYS,    ST_IDLE);
            ST_FIN_CHK:  w = mk(ACT_FIN_INIT,  1'b0, COND_READY,     ST_IDLE);
            ST_FIN_LOOP: w = mk(ACT_FIN_PLACE, 1'b0, COND_ITER_MORE, ST_FIN_LOOP);
            ST_FIN_DONE: w = mk(ACT_SET_READY, 1'b0, COND_ALWAYS,    ST_IDLE);
            ST_TXT_CHK:  w = mk(ACT_NONE,      1'b0, COND_NOT_READY, ST_ERR);
            ST_TXT_HELD: w = mk(ACT_NONE,      1'b0, COND_HELD,      ST_P_RDA);
            ST_TXT_HOLD: w = mk(ACT_HOLD,      1'b0, COND_ALWAYS,    ST_IDLE);
            ST_ERR:      w = mk(ACT_EMIT_ERR,  1'b1, COND_ALWAYS,    ST_IDLE);
            ST_END_CHK:  w = mk(ACT_NONE,      1'b0, COND_NOT_HELD,  ST_IDLE);
            ST_END_X:    w = mk(ACT_LOAD_X,    1'b0, COND_NEXT,      ST_IDLE);
            ST_P_RDA:    w = mk(ACT_RD_SLOT_A, 1'b0, COND_NEXT,      ST_IDLE);
            ST_P_RDB:    w = mk(ACT_RD_SLOT_B, 1'b0, COND_NEXT,      ST_IDLE);
            ST_P_CALC:   w = mk(ACT_CALC,      1'b0, COND_NEXT,      ST_IDLE);
            ST_P_RDX:    w = mk(ACT_RD_SQ_X,   1'b0, COND_NEXT,      ST_IDLE);
            ST_P_RDY:    w = mk(ACT_RD_SQ_Y,   1'b0, COND_NEXT,      ST_IDLE);
            ST_P_EMIT:   w = mk(ACT_EMIT_PAIR, 1'b1, COND_ALWAYS,    ST_IDLE);
            default:     w = mk(ACT_NONE,      1'b0, COND_ALWAYS,    ST_IDLE);
        endcase
        return w;
    endfunction

    always_comb
    begin
        word  = rom(upc_reg);
        stall = word.emit && st.out_busy;

        // entry point of each command, bad letter codes fall back to idle
        entry = ST_IDLE;
        if (st.fire)
        begin
            case (st.opcode)
                OP_CLEAR:  entry = ST_CLEAR;
                OP_KEY:    entry = st.letter_ok ? ST_KEY : ST_IDLE;
                OP_FINISH: entry = ST_FIN_CHK;
                OP_TEXT:   entry = st.letter_ok ? ST_TXT_CHK : ST_IDLE;
                OP_END:    entry = ST_END_CHK;
                default:   entry = ST_IDLE;
            endcase
        end

        case (word.cond)
            COND_NEXT:      jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_READY:     jump = st.key_ready;
            COND_NOT_READY: jump = !st.key_ready;
            COND_HELD:      jump = st.held_valid;
            COND_NOT_HELD:  jump = !st.held_valid;
            COND_ITER_MORE: jump = st.iter_more;
            default:        jump = 1'b0;
        endcase

        if (stall)
            upc_next = upc_reg;
        else if (word.cond == COND_DISPATCH)
            upc_next = entry;
        else if (jump)
            upc_next = word.target;
        else
            upc_next = upc_reg + 5'd1;

        ctl = word;
        if (stall)
            ctl.act = ACT_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= ST_IDLE;
        else
            upc_reg <= upc_next;
    end

endmodule

`default_nettype wire
